// ===== rtl/core/wssd_pkg.sv =====
// ----------------------------------------------------------------------------
// wssd_pkg
// Types, constants and conversion functions for the WAV sample decoder.
// ----------------------------------------------------------------------------
package wssd_pkg;

    localparam int MAX_CHANNELS_DEF = 8;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [15:0] FMT_PCM  = 16'h0001;
    localparam logic [15:0] FMT_FLT  = 16'h0003;
    localparam logic [15:0] FMT_EXT  = 16'hFFFE;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOT_WAVE = 3'd1;
    localparam logic [2:0] ST_NO_FMT   = 3'd2;
    localparam logic [2:0] ST_NO_DATA  = 3'd3;
    localparam logic [2:0] ST_BAD_TAG  = 3'd4;
    localparam logic [2:0] ST_ZERO_DEP = 3'd5;
    localparam logic [2:0] ST_BAD_DEP  = 3'd6;
    localparam logic [2:0] ST_TOO_MANY = 3'd7;

    typedef enum logic [2:0] {
        PH_HDR, PH_CHDR, PH_FMT, PH_DATA, PH_SKIP, PH_PAD, PH_ERR
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] sample_bits;
        logic [2:0]  channel;
        logic [31:0] sample_rate;
        logic [3:0]  channel_count;
        logic [2:0]  status;
        logic        last;
    } result_t;

    // position of the leading one, 32-bit magnitude
    function automatic logic [4:0] msb32(input logic [31:0] v);
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < 32; i++)
            if (v[i]) p = 5'(i);
        return p;
    endfunction

    // exact double of sign * mag * 2^-k, mag < 2^32
    function automatic logic [63:0] scaled(input logic s, input logic [31:0] mag,
                                           input logic [7:0] k);
        logic [4:0]  p;
        logic [63:0] sh;
        logic [10:0] e;
        p  = msb32(mag);
        sh = {32'd0, mag} << (6'd52 - {1'b0, p});
        e  = 11'd1023 + 11'(p) - 11'(k);
        if (mag == '0)
            return {s, 63'd0};
        return {s, e, sh[51:0]};
    endfunction

    function automatic logic [63:0] int_bits(input logic [31:0] raw, input logic [1:0] nb);
        logic [31:0] v;
        logic        neg;
        logic [7:0]  k;
        v   = raw;
        neg = 1'b0;
        k   = 8'd31;
        unique case (nb)
            2'd2:
            begin
                neg = raw[15];
                v   = {16'd0, raw[15:0]};
                k   = 8'd15;
                if (neg) v = 32'h0001_0000 - v;
            end
            2'd3:
            begin
                neg = raw[23];
                v   = {8'd0, raw[23:0]};
                k   = 8'd23;
                if (neg) v = 32'h0100_0000 - v;
            end
            default:
            begin
                neg = raw[31];
                if (neg) v = 32'd0 - raw;
            end
        endcase
        return scaled(neg, v, k);
    endfunction

    function automatic logic [63:0] widen(input logic [31:0] f);
        logic [7:0] e;
        e = f[30:23];
        if (e == 8'hFF)
        begin
            if (f[22:0] == '0) return {f[31], 11'h7FF, 52'd0};
            return {f[31], 11'h7FF, 1'b1, f[21:0], 29'd0};
        end
        if (e == 8'd0) return scaled(f[31], {9'd0, f[22:0]}, 8'd149);
        return {f[31], (e[7] ? 4'b1000 : 4'b0111), e[6:0], f[22:0], 29'd0};
    endfunction

endpackage

// ===== rtl/core/wssd_stream_if.sv =====
// ----------------------------------------------------------------------------
// wssd_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface wssd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/wav_stream_sample_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// wav_stream_sample_decoder_unit
// Parses a byte stream of a WAV file and emits decoded samples and a status.
// Path: a sample passes the drain flag, the frame RAM read and the output
// register after the last byte of its frame; a status with no frame draining
// passes its flag and the output register. Throughput: one byte per cycle when
// output is ready; input stalls as a frame is read from RAM one sample a cycle.
// Reset: asynchronous, active low; parse state clears, frame RAM is not cleared.
// ----------------------------------------------------------------------------
module wav_stream_sample_decoder_unit
    import wssd_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    wssd_stream_if.sink   in_ch,
    wssd_stream_if.source out_ch
);
    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    phase_t      phase_reg, phase_next;
    logic [31:0] cnt_reg, cnt_next, tag_reg, tag_next, len_reg, len_next;
    logic [15:0] ftag_reg, ftag_next, fch_reg, fch_next, fbits_reg, fbits_next;
    logic [31:0] rate_reg, rate_next, left_reg, left_next;
    logic [63:0] shift_reg, shift_next;
    logic [3:0]  bis_reg, bis_next;
    logic [5:0]  cif_reg, cif_next;
    logic        done_reg, done_next;
    logic [2:0]  err_reg, err_next;

    // drain sequencer
    logic        drain_reg, drain_next;
    logic [5:0]  dcnt_reg, dcnt_next, dnum_reg, dnum_next;
    logic        dstat_reg, dstat_next;
    logic [2:0]  dst_reg, dst_next;
    logic        rd_v_reg;
    logic [2:0]  rd_ch_reg;
    logic        rd_last_reg;
    logic [31:0] srate_reg, srate_next;
    logic [3:0]  scc_reg, scc_next;
    logic        pstat_reg, pstat_next;
    logic [2:0]  pst_reg, pst_next;

    // output register
    logic        ov_reg;
    result_t     ores_reg;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0] wdata, rdata;

    logic        acc;
    logic        pipe_free;
    logic [7:0]  b;
    logic        eof;
    logic [15:0] nbytes;
    logic [2:0]  st;
    logic [31:0] cl;
    logic [63:0] sh;

    assign b   = in_ch.payload[8:1];
    assign eof = in_ch.payload[0];
    assign pipe_free = !ov_reg || out_ch.ready;
    assign in_ch.ready = !drain_reg && !rd_v_reg && !pstat_reg && pipe_free;
    assign acc = in_ch.valid && in_ch.ready;
    assign nbytes = {3'd0, fbits_reg[15:3]};

    wssd_ram #(.WIDTH(64), .DEPTH(MAX_CHANNELS)) u_frame (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    always_comb
    begin
        phase_next = phase_reg; cnt_next = cnt_reg; tag_next = tag_reg; len_next = len_reg;
        ftag_next = ftag_reg; fch_next = fch_reg; fbits_next = fbits_reg;
        rate_next = rate_reg; left_next = left_reg; shift_next = shift_reg;
        bis_next = bis_reg; cif_next = cif_reg; done_next = done_reg; err_next = err_reg;
        drain_next = drain_reg; dcnt_next = dcnt_reg; dnum_next = dnum_reg;
        dstat_next = dstat_reg; dst_next = dst_reg;
        pstat_next = pstat_reg && rd_v_reg; pst_next = pst_reg;
        srate_next = srate_reg; scc_next = scc_reg;
        we = 1'b0; waddr = cif_reg[AW-1:0]; wdata = '0;
        raddr = pipe_free ? dcnt_reg[AW-1:0] : AW'(dcnt_reg - 6'd1);
        cl = len_reg; sh = '0; st = ST_OK;
        if (drain_reg && pipe_free)
        begin
            dcnt_next = dcnt_reg + 6'd1;
            if (dcnt_reg + 6'd1 == dnum_reg)
            begin
                drain_next = 1'b0;
                pstat_next = dstat_reg;
                pst_next   = dst_reg;
            end
        end
        if (acc)
        begin
            unique case (phase_reg)
                PH_HDR:
                begin
                    tag_next = {b, tag_reg[31:8]};
                    cnt_next = cnt_reg + 32'd1;
                    if (cnt_next == 32'd4 && tag_next != TAG_RIFF)
                    begin
                        err_next = ST_NOT_WAVE; phase_next = PH_ERR;
                    end
                    else if (cnt_next == 32'd12)
                    begin
                        if (tag_next != TAG_WAVE)
                        begin
                            err_next = ST_NOT_WAVE; phase_next = PH_ERR;
                        end
                        else
                        begin
                            phase_next = PH_CHDR; cnt_next = '0; tag_next = '0; len_next = '0;
                        end
                    end
                end
                PH_CHDR:
                begin
                    if (cnt_reg < 32'd4) tag_next = {b, tag_reg[31:8]};
                    else len_next = {b, len_reg[31:8]};
                    cnt_next = cnt_reg + 32'd1;
                    cl = len_next;
                    if (cnt_next == 32'd8)
                    begin
                        cnt_next = '0;
                        phase_next = PH_SKIP;
                        if (!done_reg && tag_reg == TAG_FMT && cl >= 32'd16)
                            phase_next = PH_FMT;
                        else if (!done_reg && tag_reg == TAG_DATA)
                        begin
                            if (rate_reg == '0 || fch_reg == '0) st = ST_NO_FMT;
                            else if (ftag_reg != FMT_PCM && ftag_reg != FMT_FLT) st = ST_BAD_TAG;
                            else if (nbytes == '0) st = ST_ZERO_DEP;
                            else if ((ftag_reg == FMT_PCM) ? !(fbits_reg == 16'd16 ||
                                     fbits_reg == 16'd24 || fbits_reg == 16'd32)
                                     : !(fbits_reg == 16'd32 || fbits_reg == 16'd64))
                                st = ST_BAD_DEP;
                            else if (fch_reg > 16'(MAX_CHANNELS)) st = ST_TOO_MANY;
                            if (st != ST_OK)
                            begin
                                err_next = st; phase_next = PH_ERR;
                            end
                            else
                            begin
                                done_next = 1'b1; left_next = cl; shift_next = '0;
                                bis_next = '0; cif_next = '0; phase_next = PH_DATA;
                            end
                        end
                        if (cl == '0 && phase_next != PH_ERR)
                        begin
                            phase_next = PH_CHDR; tag_next = '0; len_next = '0;
                        end
                    end
                end
                PH_FMT:
                begin
                    unique case (cnt_reg)
                        32'd0: ftag_next = {8'd0, b};
                        32'd1: ftag_next = {b, ftag_reg[7:0]};
                        32'd2: fch_next = {8'd0, b};
                        32'd3: fch_next = {b, fch_reg[7:0]};
                        32'd4: rate_next = {24'd0, b};
                        32'd5: rate_next[15:8] = b;
                        32'd6: rate_next[23:16] = b;
                        32'd7: rate_next[31:24] = b;
                        32'd14: fbits_next = {8'd0, b};
                        32'd15: fbits_next = {b, fbits_reg[7:0]};
                        32'd24: shift_next = {56'd0, b};
                        32'd25:
                            if (len_reg >= 32'd40 && ftag_reg == FMT_EXT)
                                ftag_next = {b, shift_reg[7:0]};
                        default: ;
                    endcase
                    cnt_next = cnt_reg + 32'd1;
                    if (cnt_next == len_reg)
                    begin
                        if (len_reg[0]) phase_next = PH_PAD;
                        else
                        begin
                            phase_next = PH_CHDR; cnt_next = '0; tag_next = '0; len_next = '0;
                        end
                    end
                end
                PH_SKIP:
                begin
                    cnt_next = cnt_reg + 32'd1;
                    if (cnt_next == len_reg)
                    begin
                        if (len_reg[0]) phase_next = PH_PAD;
                        else
                        begin
                            phase_next = PH_CHDR; cnt_next = '0; tag_next = '0; len_next = '0;
                        end
                    end
                end
                PH_DATA:
                begin
                    sh = shift_reg;
                    sh[{bis_reg[2:0], 3'b000} +: 8] = b;
                    shift_next = sh;
                    bis_next = bis_reg + 4'd1;
                    if ({12'd0, bis_next} == nbytes)
                    begin
                        if (ftag_reg == FMT_PCM) wdata = int_bits(sh[31:0], fbits_reg[4:3]);
                        else if (fbits_reg == 16'd32) wdata = widen(sh[31:0]);
                        else wdata = sh;
                        we = 1'b1;
                        shift_next = '0; bis_next = '0;
                        cif_next = cif_reg + 6'd1;
                        if ({10'd0, cif_next} >= fch_reg)
                        begin
                            drain_next = 1'b1; dcnt_next = '0; dnum_next = cif_next;
                            cif_next = '0;
                        end
                    end
                    left_next = left_reg - 32'd1;
                    if (left_next == '0)
                    begin
                        if (len_reg[0]) phase_next = PH_PAD;
                        else
                        begin
                            phase_next = PH_CHDR; cnt_next = '0; tag_next = '0; len_next = '0;
                        end
                    end
                end
                PH_PAD:
                begin
                    phase_next = PH_CHDR; cnt_next = '0; tag_next = '0; len_next = '0;
                end
                default: ;
            endcase
            srate_next = rate_next;
            scc_next = (fch_next > 16'd15) ? 4'd15 : fch_next[3:0];
            if (eof)
            begin
                if (phase_next == PH_ERR) st = err_next;
                else if (phase_next == PH_HDR) st = ST_NOT_WAVE;
                else if (done_next) st = ST_OK;
                else if (rate_next == '0 || fch_next == '0) st = ST_NO_FMT;
                else st = ST_NO_DATA;
                if (drain_next)
                begin
                    dstat_next = 1'b1; dst_next = st;
                end
                else
                begin
                    pstat_next = 1'b1; pst_next = st;
                end
                phase_next = PH_HDR; cnt_next = '0; tag_next = '0; len_next = '0;
                ftag_next = '0; fch_next = '0; rate_next = '0; fbits_next = '0;
                left_next = '0; shift_next = '0; bis_next = '0; cif_next = '0;
                done_next = 1'b0; err_next = '0;
            end
            else if (drain_next)
                dstat_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR; cnt_reg <= '0; tag_reg <= '0; len_reg <= '0;
            ftag_reg <= '0; fch_reg <= '0; fbits_reg <= '0; rate_reg <= '0;
            left_reg <= '0; shift_reg <= '0; bis_reg <= '0; cif_reg <= '0;
            done_reg <= 1'b0; err_reg <= '0;
            drain_reg <= 1'b0; dcnt_reg <= '0; dnum_reg <= '0;
            dstat_reg <= 1'b0; dst_reg <= '0; pstat_reg <= 1'b0; pst_reg <= '0;
            rd_v_reg <= 1'b0; rd_ch_reg <= '0; rd_last_reg <= 1'b0;
            srate_reg <= '0; scc_reg <= '0;
            ov_reg <= 1'b0; ores_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next; cnt_reg <= cnt_next; tag_reg <= tag_next;
            len_reg <= len_next; ftag_reg <= ftag_next; fch_reg <= fch_next;
            fbits_reg <= fbits_next; rate_reg <= rate_next; left_reg <= left_next;
            shift_reg <= shift_next; bis_reg <= bis_next; cif_reg <= cif_next;
            done_reg <= done_next; err_reg <= err_next;
            dcnt_reg <= dcnt_next; dnum_reg <= dnum_next;
            dstat_reg <= dstat_next; dst_reg <= dst_next; pst_reg <= pst_next;
            srate_reg <= srate_next; scc_reg <= scc_next;
            if (pipe_free)
            begin
                drain_reg <= drain_next;
                pstat_reg <= pstat_next;
                // RAM read of drain slot lands next cycle
                rd_v_reg    <= drain_reg;
                rd_ch_reg   <= dcnt_reg[2:0];
                rd_last_reg <= drain_reg && (dcnt_reg + 6'd1 == dnum_reg) && !dstat_reg;
                ov_reg <= rd_v_reg || pstat_reg;
                if (rd_v_reg)
                    ores_reg <= '{kind: 1'b0, sample_bits: rdata, channel: rd_ch_reg,
                                  sample_rate: srate_reg, channel_count: scc_reg,
                                  status: ST_OK, last: rd_last_reg};
                else
                    ores_reg <= '{kind: 1'b1, sample_bits: 64'd0, channel: 3'd0,
                                  sample_rate: srate_reg, channel_count: scc_reg,
                                  status: pst_reg, last: 1'b1};
            end
            else
            begin
                drain_reg <= drain_reg;
                pstat_reg <= pstat_reg;
            end
        end
    end

    assign out_ch.valid   = ov_reg;
    assign out_ch.payload = ores_reg;
endmodule

// ===== rtl/core/wssd_ram.sv =====
// ----------------------------------------------------------------------------
// wssd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wssd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/wssd_checker.sv =====
// ----------------------------------------------------------------------------
// wssd_checker
// Port-level checks on the decoder's output channel.
// ----------------------------------------------------------------------------
module wssd_checker
    import wssd_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    out_valid,
    input logic    out_ready,
    input result_t out_payload
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("output beat changed while stalled");
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.kind |-> out_payload.last)
        else $error("status beat without last");
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.kind |-> out_payload.sample_bits == 64'd0)
        else $error("status beat with sample bits");
    a_sample_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_payload.kind |-> out_payload.status == ST_OK)
        else $error("sample beat with status");
endmodule

bind wav_stream_sample_decoder_unit wssd_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_payload(out_ch.payload)
);

// ===== tb/sv/wav_stream_sample_decoder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// wav_stream_sample_decoder_unit_tb
// Feeds whole WAV files a byte per beat and checks every sample and status beat
// against a cycle-free model of the parser. Covers header and chunk errors,
// all PCM and float depths, extensible format, padding, truncation and
// back-pressure with random gaps on both channels.
// ----------------------------------------------------------------------------
module wav_stream_sample_decoder_unit_tb;
    import wssd_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } wav_byte_t;

    localparam int CHAN_LIMIT = MAX_CHANNELS_DEF;
    localparam int STALL_LIMIT = 5000;

    class decoder_scoreboard;
        result_t     sample_q[$];
        int          errors;
        phase_t      phase;
        logic [31:0] field_cnt;
        logic [31:0] ctag;
        logic [31:0] clen;
        logic [15:0] ftag;
        logic [15:0] fch;
        logic [31:0] frate;
        logic [15:0] fbits;
        logic [31:0] bytes_left;
        logic [63:0] shift_acc;
        int          byte_pos;
        int          chan_pos;
        logic [63:0] frame_buf [CHAN_LIMIT];
        bit          data_seen;
        logic [2:0]  err_code;
        result_t     step_q[$];

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase = PH_HDR;
            field_cnt = 0;
            ctag = 0;
            clen = 0;
            ftag = 0;
            fch = 0;
            frate = 0;
            fbits = 0;
            bytes_left = 0;
            shift_acc = 0;
            byte_pos = 0;
            chan_pos = 0;
            data_seen = 0;
            err_code = 0;
        endfunction

        function int pending();
            return sample_q.size();
        endfunction

        function logic [63:0] to_double(logic s, logic [63:0] mag, int k);
            int p;
            logic [63:0] m;
            p = 0;
            if (mag == 0)
                return {s, 63'd0};
            for (int i = 0; i < 64; i++)
                if (mag[i]) p = i;
            m = mag << (52 - p);
            return {s, 11'(1023 + p - k), m[51:0]};
        endfunction

        function logic [63:0] pcm_double(logic [63:0] raw, int n);
            logic [63:0] top;
            logic [63:0] v;
            top = 64'd1 << (n - 1);
            v = raw & ((top << 1) - 1);
            if (v & top)
                return to_double(1'b1, (top << 1) - v, n - 1);
            return to_double(1'b0, v, n - 1);
        endfunction

        function logic [63:0] float_double(logic [31:0] f);
            logic [7:0]  e;
            logic [51:0] m;
            e = f[30:23];
            m = 52'(f[22:0]) << 29;
            if (e == 8'hFF)
            begin
                if (f[22:0] == 0)
                    return {f[31], 11'h7FF, 52'd0};
                return {f[31], 11'h7FF, m | (52'd1 << 51)};
            end
            if (e == 0)
                return to_double(f[31], 64'(f[22:0]), 149);
            return {f[31], 11'(e + 896), m};
        endfunction

        function void emit(logic kind, logic [63:0] bits, int ch, logic [2:0] st);
            result_t r;
            r.kind = kind;
            r.sample_bits = bits;
            r.channel = 3'(ch);
            r.sample_rate = frate;
            r.channel_count = (fch > 15) ? 4'd15 : fch[3:0];
            r.status = st;
            r.last = 1'b0;
            step_q.push_back(r);
        endfunction

        function void abort(logic [2:0] code);
            err_code = code;
            phase = PH_ERR;
        endfunction

        function void next_chunk();
            phase = PH_CHDR;
            field_cnt = 0;
            ctag = 0;
            clen = 0;
        endfunction

        function void close_body();
            if (clen[0])
                phase = PH_PAD;
            else
                next_chunk();
        endfunction

        function bit depth_valid();
            if (ftag == FMT_PCM)
                return fbits == 16 || fbits == 24 || fbits == 32;
            return fbits == 32 || fbits == 64;
        endfunction

        function void open_body();
            field_cnt = 0;
            if (!data_seen && ctag == TAG_FMT && clen >= 16)
                phase = PH_FMT;
            else if (!data_seen && ctag == TAG_DATA)
            begin
                if (frate == 0 || fch == 0)
                begin
                    abort(ST_NO_FMT);
                    return;
                end
                if (ftag != FMT_PCM && ftag != FMT_FLT)
                begin
                    abort(ST_BAD_TAG);
                    return;
                end
                if (fbits / 8 == 0)
                begin
                    abort(ST_ZERO_DEP);
                    return;
                end
                if (!depth_valid())
                begin
                    abort(ST_BAD_DEP);
                    return;
                end
                if (fch > CHAN_LIMIT)
                begin
                    abort(ST_TOO_MANY);
                    return;
                end
                data_seen = 1;
                bytes_left = clen;
                shift_acc = 0;
                byte_pos = 0;
                chan_pos = 0;
                phase = PH_DATA;
            end
            else
                phase = PH_SKIP;
            if (clen == 0)
                close_body();
        endfunction

        function void fmt_field(logic [7:0] b);
            int i;
            i = field_cnt;
            if (i == 0) ftag = b;
            else if (i == 1) ftag[15:8] = b;
            else if (i == 2) fch = b;
            else if (i == 3) fch[15:8] = b;
            else if (i >= 4 && i <= 7)
            begin
                if (i == 4) frate = 0;
                frate = frate | (32'(b) << (8 * (i - 4)));
            end
            else if (i == 14) fbits = b;
            else if (i == 15) fbits[15:8] = b;
            else if (i == 24) shift_acc = b;
            else if (i == 25 && clen >= 40 && ftag == FMT_EXT)
                ftag = {b, shift_acc[7:0]};
        endfunction

        function void note_byte(logic [7:0] b, logic eof);
            logic [63:0] v;
            logic [2:0]  st;
            step_q.delete();
            case (phase)
                PH_HDR:
                begin
                    ctag = {b, ctag[31:8]};
                    field_cnt++;
                    if (field_cnt == 4 && ctag != TAG_RIFF)
                        abort(ST_NOT_WAVE);
                    else if (field_cnt == 12)
                    begin
                        if (ctag != TAG_WAVE) abort(ST_NOT_WAVE);
                        else next_chunk();
                    end
                end
                PH_CHDR:
                begin
                    if (field_cnt < 4)
                        ctag = {b, ctag[31:8]};
                    else
                        clen = clen | (32'(b) << (8 * (field_cnt - 4)));
                    field_cnt++;
                    if (field_cnt == 8)
                        open_body();
                end
                PH_FMT:
                begin
                    fmt_field(b);
                    field_cnt++;
                    if (field_cnt == clen) close_body();
                end
                PH_SKIP:
                begin
                    field_cnt++;
                    if (field_cnt == clen) close_body();
                end
                PH_DATA:
                begin
                    shift_acc = shift_acc | (64'(b) << (8 * (byte_pos % 8)));
                    byte_pos++;
                    if (byte_pos == fbits / 8)
                    begin
                        if (ftag == FMT_PCM) v = pcm_double(shift_acc, fbits);
                        else if (fbits == 32) v = float_double(shift_acc[31:0]);
                        else v = shift_acc;
                        if (chan_pos < CHAN_LIMIT) frame_buf[chan_pos] = v;
                        shift_acc = 0;
                        byte_pos = 0;
                        chan_pos++;
                        if (chan_pos >= fch)
                        begin
                            for (int c = 0; c < chan_pos && c < CHAN_LIMIT; c++)
                                emit(1'b0, frame_buf[c], c, ST_OK);
                            chan_pos = 0;
                        end
                    end
                    bytes_left--;
                    if (bytes_left == 0) close_body();
                end
                PH_PAD:
                    next_chunk();
                default:
                    ;
            endcase
            if (eof)
            begin
                if (phase == PH_ERR) st = err_code;
                else if (phase == PH_HDR) st = ST_NOT_WAVE;
                else if (data_seen) st = ST_OK;
                else if (frate == 0 || fch == 0) st = ST_NO_FMT;
                else st = ST_NO_DATA;
                emit(1'b1, 64'd0, 0, st);
                clear();
            end
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last = 1'b1;
            foreach (step_q[i])
                sample_q.push_back(step_q[i]);
        endfunction

        function void check(result_t got);
            result_t want;
            if (sample_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: %p", got);
                return;
            end
            want = sample_q.pop_front();
            if (got.kind !== want.kind || got.sample_bits !== want.sample_bits ||
                got.channel !== want.channel || got.sample_rate !== want.sample_rate ||
                got.channel_count !== want.channel_count ||
                got.status !== want.status || got.last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_gaps;
    bit   hold_req;
    int   stall_cnt;
    logic [7:0] file_q[$];
    decoder_scoreboard sb;

    wssd_stream_if #(.payload_t(wav_byte_t)) in_if ();
    wssd_stream_if #(.payload_t(result_t)) out_if ();

    wav_stream_sample_decoder_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if.sink),
        .out_ch (out_if.source)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic bit gap();
        return !no_gaps && $urandom_range(0, 99) < 38;
    endfunction

    // bytes past the fourth are zero
    function automatic void put_le(logic [31:0] v, int n);
        for (int i = 0; i < n; i++)
            file_q.push_back(i < 4 ? v[8 * i +: 8] : 8'd0);
    endfunction

    function automatic void put_rand(int n);
        for (int i = 0; i < n; i++)
            file_q.push_back(8'($urandom));
    endfunction

    function automatic void put_riff();
        put_le(TAG_RIFF, 4);
        put_le($urandom, 4);
        put_le(TAG_WAVE, 4);
    endfunction

    function automatic void put_chunk(logic [31:0] tag, logic [31:0] len);
        put_le(tag, 4);
        put_le(len, 4);
    endfunction

    function automatic void put_fmt(logic [15:0] tag, logic [15:0] ch, logic [31:0] rate,
                                    logic [15:0] bits, int len, logic [15:0] sub);
        logic [7:0] body [40];
        for (int i = 0; i < 40; i++)
            body[i] = 8'($urandom);
        {body[1], body[0]} = tag;
        {body[3], body[2]} = ch;
        {body[7], body[6], body[5], body[4]} = rate;
        {body[15], body[14]} = bits;
        {body[25], body[24]} = sub;
        put_chunk(TAG_FMT, len);
        for (int i = 0; i < len; i++)
            file_q.push_back(i < 40 ? body[i] : 8'($urandom));
        if (len % 2) put_rand(1);
    endfunction

    function automatic void put_junk(int len);
        put_chunk(32'h4B4E_554A, len);
        put_rand(len + len % 2);
    endfunction

    task automatic send_byte(logic [7:0] b, logic eof);
        while (gap())
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.payload <= '{data_byte: b, end_of_file: eof};
        do @(posedge clk); while (!in_if.ready);
        sb.note_byte(b, eof);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], i == file_q.size() - 1);
        file_q.delete();
    endtask

    task automatic wav_with_data(logic [15:0] tag, logic [15:0] ch, logic [15:0] bits,
                                 logic [31:0] samples[$]);
        put_riff();
        put_fmt(tag, ch, 48000, bits, 16, 0);
        put_chunk(TAG_DATA, samples.size() * (bits / 8));
        foreach (samples[i])
            put_le(samples[i], bits / 8);
        send_file();
    endtask

    task automatic random_file();
        int kind;
        int mode;
        logic [15:0] tag;
        logic [15:0] ch;
        logic [15:0] bits;
        int bpf;
        int len;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            if ($urandom_range(0, 1)) put_riff();
            put_rand($urandom_range(1, 30));
            send_file();
            return;
        end
        mode = $urandom_range(0, 4);
        tag = mode < 3 ? FMT_PCM : FMT_FLT;
        bits = mode == 0 ? 16 : mode == 1 ? 24 : mode == 4 ? 64 : 32;
        ch = $urandom_range(1, 8);
        if ($urandom_range(0, 11) == 0) ch = $urandom_range(0, 12);
        if ($urandom_range(0, 11) == 0) bits = $urandom_range(0, 72);
        if ($urandom_range(0, 11) == 0) tag = $urandom;
        put_riff();
        if ($urandom_range(0, 3) == 0) put_junk($urandom_range(0, 5));
        if ($urandom_range(0, 3) == 0)
            put_fmt(FMT_EXT, ch, $urandom, bits, 40, tag);
        else
            put_fmt(tag, ch, $urandom_range(1, 200000), bits, 16, 0);
        bpf = ch * (bits / 8);
        len = $urandom_range(0, 4) * bpf;
        if ($urandom_range(0, 3) == 0 && bpf > 0) len += $urandom_range(0, bpf - 1);
        put_chunk(TAG_DATA, len);
        put_rand(len + len % 2);
        if ($urandom_range(0, 2) == 0) put_fmt(FMT_PCM, 1, 8000, 16, 16, 0);
        if ($urandom_range(0, 2) == 0) put_junk($urandom_range(0, 3));
        if (kind == 1)
            while (file_q.size() > 1 && $urandom_range(0, 3) != 0)
                void'(file_q.pop_back());
        send_file();
    endtask

    initial
    begin
        out_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_if.valid && out_if.ready)
                sb.check(out_if.payload);
            if (hold_req)
            begin
                hold_req = 0;
                out_if.ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            out_if.ready <= !gap();
        end
    end

    initial
    begin
        stall_cnt = 0;
        forever
        begin
            @(posedge clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("wav_stream_sample_decoder_unit regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] s[$];
        sb = new();
        no_gaps = 0;
        hold_req = 0;
        in_if.valid = 1'b0;
        in_if.payload = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put_le(32'h5846_4952, 4);
        put_rand(10);
        send_file();
        put_le(TAG_RIFF, 8);
        put_le(32'h5845_4157, 4);
        send_file();
        put_rand(1);
        send_file();
        put_riff();
        put_chunk(TAG_DATA, 4);
        put_rand(4);
        send_file();
        put_riff();
        put_fmt(16'h0002, 1, 8000, 16, 16, 0);
        put_chunk(TAG_DATA, 0);
        send_file();
        put_riff();
        put_fmt(FMT_PCM, 1, 8000, 4, 16, 0);
        put_chunk(TAG_DATA, 0);
        send_file();
        put_riff();
        put_fmt(FMT_PCM, 1, 8000, 12, 16, 0);
        put_chunk(TAG_DATA, 0);
        send_file();
        put_riff();
        put_fmt(FMT_FLT, 9, 8000, 32, 16, 0);
        put_chunk(TAG_DATA, 0);
        send_file();
        put_riff();
        put_fmt(FMT_PCM, 20, 32'hFFFF_FFFF, 16, 16, 0);
        put_chunk(TAG_DATA, 2);
        put_rand(2);
        send_file();

        put_riff();
        put_junk(3);
        put_fmt(FMT_PCM, 2, 44100, 16, 16, 0);
        put_chunk(TAG_DATA, 8);
        put_le(32'h7FFF_8000, 4);
        put_le(32'hFFFF_0000, 4);
        send_file();
        s = '{32'h80_0000, 32'h7F_FFFF, 32'hFF_FFFF, 32'h0};
        wav_with_data(FMT_PCM, 1, 24, s);
        s = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF};
        wav_with_data(FMT_PCM, 2, 32, s);
        s = '{32'h7F80_0000, 32'h7FC0_0001, 32'h0000_0001, 32'h8000_0000,
              32'h3F80_0000, 32'h7F7F_FFFF, 32'hFF80_0000, 32'h807F_FFFF, 32'hFFFF_FFFF};
        wav_with_data(FMT_FLT, 3, 32, s);
        s = '{32'h0, 32'h3FF0_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        wav_with_data(FMT_FLT, 1, 64, s);
        s = '{};
        for (int i = 0; i < 8; i++) s.push_back($urandom);
        wav_with_data(FMT_PCM, 8, 16, s);

        put_riff();
        put_fmt(FMT_EXT, 1, 96000, 32, 40, FMT_FLT);
        put_chunk(TAG_DATA, 8);
        put_rand(8);
        send_file();
        put_riff();
        put_fmt(FMT_PCM, 1, 8000, 16, 14, 0);
        put_chunk(TAG_DATA, 2);
        put_rand(2);
        send_file();
        put_riff();
        put_fmt(FMT_PCM, 2, 22050, 16, 16, 0);
        void'(file_q.pop_back());
        void'(file_q.pop_back());
        send_file();
        put_riff();
        put_fmt(FMT_PCM, 2, 8000, 16, 16, 0);
        put_chunk(TAG_DATA, 7);
        put_rand(8);
        put_fmt(FMT_FLT, 1, 1000, 32, 16, 0);
        put_chunk(TAG_DATA, 4);
        put_rand(4);
        send_file();
        put_riff();
        put_fmt(FMT_PCM, 1, 8000, 24, 16, 0);
        put_chunk(TAG_DATA, 0);
        put_junk(1);
        send_file();
        put_riff();
        put_fmt(FMT_PCM, 1, 8000, 16, 16, 0);
        send_file();

        for (int f = 0; f < 30; f++)
        begin
            no_gaps = (f >= 10 && f < 15);
            if (f == 5) hold_req = 1;
            random_file();
        end
        no_gaps = 0;
        in_if.valid <= 1'b0;

        while (sb.pending() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("wav_stream_sample_decoder_unit regression: pass");
        else
            $display("wav_stream_sample_decoder_unit regression: fail");
        $finish;
    end

endmodule

// ===== wav_stream_sample_decoder_unit.f =====
rtl/core/wssd_pkg.sv
rtl/core/wssd_stream_if.sv
rtl/core/wssd_ram.sv
rtl/core/wav_stream_sample_decoder_unit.sv
rtl/core/wssd_checker.sv
tb/sv/wav_stream_sample_decoder_unit_tb.sv
